/* hdl/dssi_pkg.sv */
// Package: shared widths, opcodes and controller/datapath command and status types.
package dssi_pkg;

  localparam int OP_W     = 2;
  localparam int LETTER_W = 2;
  localparam int STATE_W  = 6;
  localparam int MASK_W   = 64;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 7;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OP_W-1:0] OP_APPLY   = 2'd2;

  localparam logic REG_STATES_IN_USE = 1'b0;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic apply;
    logic scan_last;
  } sts_t;

endpackage

/* hdl/dssi_if.sv */
// Interfaces: input word channel and result word channel.
interface dssi_in_if;
  logic                          valid;
  logic                          ready;
  logic [dssi_pkg::OP_W-1:0]     opcode;
  logic [dssi_pkg::LETTER_W-1:0] letter;
  logic [dssi_pkg::STATE_W-1:0]  source_state;
  logic [dssi_pkg::STATE_W-1:0]  target_state;

  modport source (output valid, opcode, letter, source_state, target_state, input ready);
  modport sink   (input valid, opcode, letter, source_state, target_state, output ready);
endinterface

interface dssi_out_if;
  logic                         valid;
  logic                         ready;
  logic [dssi_pkg::MASK_W-1:0]  active_mask;
  logic [dssi_pkg::COUNT_W-1:0] active_count;
  logic                         synchronized;
  logic [dssi_pkg::STATE_W-1:0] sole_state;

  modport source (output valid, active_mask, active_count, synchronized, sole_state,
                  input ready);
  modport sink   (input valid, active_mask, active_count, synchronized, sole_state,
                  output ready);
endinterface

/* hdl/dssi_ctrl.sv */
// Controller: sequences capture, table scan, commit and result hand-off.
module dssi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dssi_pkg::sts_t sts,
  output dssi_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FLUSH  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.apply) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/dssi_dp.sv */
// Datapath: transition table memory, active set, image builder and result register.
module dssi_dp #(
  parameter int MAX_STATES = 64,
  parameter int LETTERS    = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dssi_pkg::cmd_t                cmd,
  output dssi_pkg::sts_t                sts,
  input  logic [dssi_pkg::OP_W-1:0]     in_opcode,
  input  logic [dssi_pkg::LETTER_W-1:0] in_letter,
  input  logic [dssi_pkg::STATE_W-1:0]  in_source_state,
  input  logic [dssi_pkg::STATE_W-1:0]  in_target_state,
  input  logic [dssi_pkg::CFG_W-1:0]    states_in_use,
  output logic [dssi_pkg::MASK_W-1:0]   out_active_mask,
  output logic [dssi_pkg::COUNT_W-1:0]  out_active_count,
  output logic                          out_synchronized,
  output logic [dssi_pkg::STATE_W-1:0]  out_sole_state
);

  localparam int ENTRIES = LETTERS * MAX_STATES;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(MAX_STATES);
  localparam int CW      = $clog2(MAX_STATES + 1);

  logic [dssi_pkg::STATE_W-1:0] tbl_mem [ENTRIES];

  logic [dssi_pkg::OP_W-1:0]     op_r;
  logic [dssi_pkg::LETTER_W-1:0] letter_r;
  logic [dssi_pkg::STATE_W-1:0]  src_r, dst_r;

  logic [MAX_STATES-1:0] mask_r, mask_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         sole_r, sole_nxt;

  logic [MAX_STATES-1:0] image_r, image_nxt;
  logic [CW-1:0]         icount_r, icount_nxt;
  logic [IW-1:0]         isole_r, isole_nxt;

  logic [IW-1:0]                idx_r;
  logic                         rd_act_r;
  logic [dssi_pkg::STATE_W-1:0] rd_data_r;
  logic [IW-1:0]                tgt;
  logic                         tgt_ok;

  logic [AW-1:0]         wr_addr, rd_addr;
  logic                  load_ok, do_restart;
  logic [CW-1:0]         n_used;
  logic [MAX_STATES-1:0] rst_mask;

  logic [dssi_pkg::MASK_W-1:0]  omask_r;
  logic [dssi_pkg::COUNT_W-1:0] ocount_r;
  logic                         osync_r;
  logic [dssi_pkg::STATE_W-1:0] osole_r;

  assign sts.apply     = (op_r == dssi_pkg::OP_APPLY) && (int'(letter_r) < LETTERS);
  assign sts.scan_last = (idx_r == IW'(MAX_STATES - 1));

  assign load_ok = (op_r == dssi_pkg::OP_LOAD) && (int'(letter_r) < LETTERS) &&
                   (int'(src_r) < MAX_STATES) && (int'(dst_r) < MAX_STATES);
  assign do_restart = cmd.exec && (op_r == dssi_pkg::OP_RESTART);

  assign wr_addr = AW'(int'(letter_r) * MAX_STATES + int'(src_r));
  assign rd_addr = AW'(int'(letter_r) * MAX_STATES + int'(idx_r));

  always_comb begin
    if (states_in_use == '0) begin
      n_used = CW'(1);
    end else if (int'(states_in_use) > MAX_STATES) begin
      n_used = CW'(MAX_STATES);
    end else begin
      n_used = CW'(states_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_STATES; i++) begin
      rst_mask[i] = (i < int'(n_used));
    end
  end

  // image build: merge one table read per cycle
  assign tgt    = rd_data_r[IW-1:0];
  assign tgt_ok = rd_act_r && (int'(rd_data_r) < MAX_STATES);

  always_comb begin
    image_nxt  = image_r;
    icount_nxt = icount_r;
    isole_nxt  = isole_r;
    if (cmd.scan_start) begin
      image_nxt  = '0;
      icount_nxt = '0;
      isole_nxt  = '0;
    end else if (tgt_ok && !image_r[tgt]) begin
      image_nxt[tgt] = 1'b1;
      icount_nxt     = icount_r + CW'(1);
      if (icount_r == '0) begin
        isole_nxt = tgt;
      end
    end
  end

  always_comb begin
    mask_nxt  = mask_r;
    count_nxt = count_r;
    sole_nxt  = sole_r;
    if (do_restart) begin
      mask_nxt  = rst_mask;
      count_nxt = n_used;
      sole_nxt  = '0;
    end else if (cmd.commit) begin
      mask_nxt  = image_r;
      count_nxt = icount_r;
      sole_nxt  = isole_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && load_ok) begin
      tbl_mem[wr_addr] <= dst_r;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '1;
      count_r  <= CW'(MAX_STATES);
      sole_r   <= '0;
      idx_r    <= '0;
      rd_act_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      count_r  <= count_nxt;
      sole_r   <= sole_nxt;
      rd_act_r <= cmd.scan_step && mask_r[idx_r];
      if (cmd.scan_start) begin
        idx_r <= '0;
      end else if (cmd.scan_step) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    image_r  <= image_nxt;
    icount_r <= icount_nxt;
    isole_r  <= isole_nxt;
    if (cmd.capture) begin
      op_r     <= in_opcode;
      letter_r <= in_letter;
      src_r    <= in_source_state;
      dst_r    <= in_target_state;
    end
    if (cmd.out_load) begin
      omask_r  <= dssi_pkg::MASK_W'(mask_r);
      ocount_r <= dssi_pkg::COUNT_W'(count_r);
      osync_r  <= (count_r == CW'(1));
      osole_r  <= (count_r == CW'(1)) ? dssi_pkg::STATE_W'(sole_r) : '0;
    end
  end

  assign out_active_mask  = omask_r;
  assign out_active_count = ocount_r;
  assign out_synchronized = osync_r;
  assign out_sole_state   = osole_r;

endmodule

/* hdl/dfa_state_set_image_core.sv */
// Top level: automaton subset-image engine with APB register port.
//
// channel  role    handshake            word
// in_ch    sink    valid/ready          opcode, letter, source_state, target_state
// out_ch   source  valid/ready          active_mask, active_count, synchronized, sole_state
// cfg      APB     psel/penable/pready  states_in_use at byte address 0
//
// One word at a time. Load, restart and unused opcodes pass from capture through exec
// to the result; a letter also runs the scan, which reads one table entry per state
// from the table memory, and then commits the image.
// rst_n is synchronous: active set becomes all states, table contents are undefined.
// A result waits in the output register; a stalled out_ch keeps the next result in
// the active set, with the controller waiting, and blocks further input until it is handed over.
module dfa_state_set_image_core #(
  parameter int MAX_STATES = 64,
  parameter int LETTERS    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  dssi_in_if.sink            in_ch,
  dssi_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dssi_pkg::cmd_t cmd;
  dssi_pkg::sts_t sts;

  logic [dssi_pkg::CFG_W-1:0] states_in_use_r;
  logic                       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == dssi_pkg::REG_STATES_IN_USE);
  assign prdata  = reg_hit ? 32'(states_in_use_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r <= dssi_pkg::CFG_W'(64);
    end else if (psel && penable && pwrite && reg_hit) begin
      states_in_use_r <= pwdata[dssi_pkg::CFG_W-1:0];
    end
  end

  dssi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dssi_dp #(
    .MAX_STATES (MAX_STATES),
    .LETTERS    (LETTERS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_letter        (in_ch.letter),
    .in_source_state  (in_ch.source_state),
    .in_target_state  (in_ch.target_state),
    .states_in_use    (states_in_use_r),
    .out_active_mask  (out_ch.active_mask),
    .out_active_count (out_ch.active_count),
    .out_synchronized (out_ch.synchronized),
    .out_sole_state   (out_ch.sole_state)
  );

endmodule
